/* hdl/ebm_pkg.sv */
// Shared types, constants and register indexes for the encoder button menu controller.
// No dependencies; every other file of the block imports this package.
package ebm_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Field widths.
  localparam int unsigned TimeW   = 32;
  localparam int unsigned GapW    = 16;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned ValueW  = 5;
  localparam int unsigned StepW   = 4;
  localparam int unsigned AngleW  = 9;
  localparam int unsigned CursorW = 2;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Default depth of the event queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Reset values.
  localparam logic [GapW-1:0]    PressGapReset   = 16'd50;
  localparam logic [TicksW-1:0]  LongTicksReset  = 16'd500;
  localparam logic [ValueW-1:0]  ValueMinReset   = 5'd8;
  localparam logic [ValueW-1:0]  ValueMaxReset   = 5'd18;
  localparam logic [StepW-1:0]   AngleStepReset  = 4'd9;
  localparam logic [TicksW-1:0]  HoldCountReset  = 16'd100;

  // Cursor entries.
  localparam logic [CursorW-1:0] CursorAll   = 2'd1;
  localparam logic [CursorW-1:0] CursorLeft  = 2'd2;
  localparam logic [CursorW-1:0] CursorRight = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_GAP  = 3'd0,
    CFG_LONG_TICKS = 3'd1,
    CFG_VALUE_MIN  = 3'd2,
    CFG_VALUE_MAX  = 3'd3,
    CFG_ANGLE_STEP = 3'd4
  } ebm_cfg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic [GapW-1:0]   press_gap_ms;
    logic [TicksW-1:0] long_press_ticks;
    logic [ValueW-1:0] value_min;
    logic [ValueW-1:0] value_max;
    logic [StepW-1:0]  angle_step;
  } ebm_cfg_t;

  // One classified tick as it travels from front to back.
  typedef struct packed {
    logic edge_seen;  // rising edge on the encoder clock line
    logic forward;    // data line differed from clock line on that edge
    logic btn_low;    // button pressed this tick
    logic gap_hit;    // low sample after a gap longer than press_gap_ms
  } ebm_event_t;

endpackage

/* hdl/ebm_front.sv */
// Front part: accepts input transactions and classifies each tick into an event.
// Depends on ebm_pkg; feeds ebm_queue.
module ebm_front
  import ebm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ebm_cfg_t           cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic               enc_a_i,
  input  logic               enc_b_i,
  input  logic               button_level_i,
  output logic               evt_valid_o,
  input  logic               evt_ready_i,
  output ebm_event_t         evt_o
);

  logic             last_clock_level_q, last_clock_level_d;
  logic [TimeW-1:0] last_low_time_q, last_low_time_d;
  logic [TimeW-1:0] gap;
  logic             accept;

  // The front keeps only the state that depends on the input stream alone.
  assign in_ready_o  = evt_ready_i;
  assign evt_valid_o = in_valid_i;
  assign accept      = in_valid_i & evt_ready_i;

  // Classification of the current tick.
  always_comb begin
    gap                = now_ms_i - last_low_time_q;
    evt_o.edge_seen    = enc_a_i & ~last_clock_level_q;
    evt_o.forward      = enc_b_i ^ enc_a_i;
    evt_o.btn_low      = ~button_level_i;
    evt_o.gap_hit      = gap > {{(TimeW-GapW){1'b0}}, cfg_i.press_gap_ms};
  end

  // History update on each accepted transaction.
  always_comb begin
    last_clock_level_d = last_clock_level_q;
    last_low_time_d    = last_low_time_q;
    if (accept) begin
      last_clock_level_d = enc_a_i;
      if (!button_level_i) begin
        last_low_time_d = now_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_clock_level_q <= 1'b0;
      last_low_time_q    <= '0;
    end else begin
      last_clock_level_q <= last_clock_level_d;
      last_low_time_q    <= last_low_time_d;
    end
  end

endmodule

/* hdl/ebm_queue.sv */
// Short event queue between the front and the back, so each side stalls on its own.
// Depends on ebm_pkg for the event type.
module ebm_queue
  import ebm_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  ebm_event_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output ebm_event_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ebm_event_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/ebm_back.sv */
// Back part: applies events to the menu state and holds the result for the output stream.
// Depends on ebm_pkg; fed by ebm_queue.
module ebm_back
  import ebm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebm_cfg_t            cfg_i,
  input  logic                evt_valid_i,
  output logic                evt_ready_o,
  input  ebm_event_t          evt_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic [CursorW-1:0] cursor_q, cursor_d;
  logic               edit_q, edit_d;
  logic               lock_q, lock_d;
  logic [ValueW-1:0]  val_all_q, val_all_d;
  logic [ValueW-1:0]  val_left_q, val_left_d;
  logic [ValueW-1:0]  val_right_q, val_right_d;
  logic [TicksW-1:0]  hold_q, hold_d;
  logic               long_q, long_d;
  logic               armed_q, armed_d;
  logic               kind_q, kind_d;
  logic               rotated_q, rotated_d;
  logic               out_valid_q, out_valid_d;
  logic               step;
  logic [ValueW-1:0]  sel_val, new_val;
  logic               moved;
  logic [AngleW-1:0]  angle_all, angle_left, angle_right;
  logic               all_matches;

  // The result register is free when empty or being taken this cycle.
  assign evt_ready_o = ~out_valid_q | out_ready_i;
  assign step        = evt_valid_i & evt_ready_o;

  // Angle of one setting relative to the minimum.
  function automatic logic [AngleW-1:0] angle_of(input logic [ValueW-1:0] v,
                                                 input logic [ValueW-1:0] vmin,
                                                 input logic [StepW-1:0]  astep);
    logic [ValueW-1:0] diff;
    diff = v - vmin;
    if (v < vmin) begin
      angle_of = '0;
    end else begin
      angle_of = AngleW'(astep) * AngleW'(diff);
    end
  endfunction

  // Value step of the selected entry.
  always_comb begin
    case (cursor_q)
      CursorLeft:  sel_val = val_left_q;
      CursorRight: sel_val = val_right_q;
      default:     sel_val = val_all_q;
    endcase
    moved   = 1'b0;
    new_val = sel_val;
    if (evt_i.forward && (sel_val < cfg_i.value_max)) begin
      new_val = sel_val + 1'b1;
      moved   = 1'b1;
    end else if (!evt_i.forward && (sel_val > cfg_i.value_min)) begin
      new_val = sel_val - 1'b1;
      moved   = 1'b1;
    end
  end

  // State update for one event: rotation first, then the button.
  always_comb begin
    cursor_d    = cursor_q;
    edit_d      = edit_q;
    lock_d      = lock_q;
    val_all_d   = val_all_q;
    val_left_d  = val_left_q;
    val_right_d = val_right_q;
    hold_d      = hold_q;
    long_d      = long_q;
    armed_d     = armed_q;
    kind_d      = kind_q;
    rotated_d   = rotated_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (step) begin
      out_valid_d = 1'b1;
      rotated_d   = evt_i.edge_seen;
      if (evt_i.edge_seen) begin
        if (!lock_q) begin
          if (!edit_q) begin
            if (evt_i.forward) begin
              cursor_d = (cursor_q == CursorRight) ? CursorAll : cursor_q + 1'b1;
            end else begin
              cursor_d = (cursor_q == CursorAll || cursor_q == 2'd0) ? CursorRight
                                                                     : cursor_q - 1'b1;
            end
          end else if (moved) begin
            case (cursor_q)
              CursorLeft:  val_left_d  = new_val;
              CursorRight: val_right_d = new_val;
              default: begin
                val_all_d   = new_val;
                val_left_d  = new_val;
                val_right_d = new_val;
              end
            endcase
          end
        end
        // Entry "all" follows left when both sides agree.
        if (val_left_d == val_right_d) begin
          val_all_d = val_left_d;
        end
      end
      if (evt_i.btn_low) begin
        if (evt_i.gap_hit) begin
          hold_d  = cfg_i.long_press_ticks;
          long_d  = 1'b0;
          armed_d = 1'b1;
        end else if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end else begin
          long_d = 1'b1;
        end
      end else if (armed_q) begin
        if (long_q) begin
          armed_d = 1'b0;
          kind_d  = 1'b1;
          lock_d  = ~lock_q;
        end else if (!lock_q) begin
          armed_d = 1'b0;
          kind_d  = 1'b0;
          edit_d  = ~edit_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= CursorAll;
      edit_q      <= 1'b0;
      lock_q      <= 1'b0;
      val_all_q   <= ValueMinReset;
      val_left_q  <= ValueMinReset;
      val_right_q <= ValueMinReset;
      hold_q      <= HoldCountReset;
      long_q      <= 1'b0;
      armed_q     <= 1'b0;
      kind_q      <= 1'b0;
      rotated_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      edit_q      <= edit_d;
      lock_q      <= lock_d;
      val_all_q   <= val_all_d;
      val_left_q  <= val_left_d;
      val_right_q <= val_right_d;
      hold_q      <= hold_d;
      long_q      <= long_d;
      armed_q     <= armed_d;
      kind_q      <= kind_d;
      rotated_q   <= rotated_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result fields come from the state and cfg_i; the state only changes with a new result.
  always_comb begin
    angle_all   = angle_of(val_all_q, cfg_i.value_min, cfg_i.angle_step);
    angle_left  = angle_of(val_left_q, cfg_i.value_min, cfg_i.angle_step);
    angle_right = angle_of(val_right_q, cfg_i.value_min, cfg_i.angle_step);
    all_matches = (val_left_q == val_all_q) && (val_right_q == val_all_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {6'd0, rotated_q, kind_q, all_matches, angle_right, angle_left,
                        angle_all, lock_q, edit_q, cursor_q};

endmodule

/* hdl/encoder_button_menu_controller_top.sv */
// Top level of the encoder button menu controller: configuration registers,
// front classifier, event queue and back state machine. Depends on ebm_pkg.
//
// Usage: each input transaction on the s_axis channel is one loop tick carrying
// the timestamp, the encoder A/B levels and the button level. Each tick yields
// exactly one result transaction on the m_axis channel with the cursor, mode
// flags, the three angles, the match flag, the last press kind and a rotation flag.
// A result passes through the event queue and the back's result register before it is
// offered. Throughput: one tick per cycle while the receiver keeps up; the back applies
// one event per cycle through a single update step, and the front classifies one tick
// per cycle. The event queue (QueueDepth entries) lets the input side keep going while
// a result waits; when the receiver stalls, the queue fills and s_axis_tready drops.
// Reset clears the menu state to cursor "all", editing and lock off, all settings
// at 8, and loads the register defaults (gap 50 ms, long press 500 ticks, min 8,
// max 18, step 9). The configuration channel is always ready; the user must write it
// only while no tick is in flight, as the block itself does not enforce this.
module encoder_button_menu_controller_top
  import ebm_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: now_ms[31:0], enc_a[32], enc_b[33], button_level[34], zeros[39:35]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: cursor[1:0], editing[2], locked[3], angle_all[12:4], angle_left[21:13],
  // angle_right[30:22], all_matches[31], last_press_long[32], rotated[33], zeros[39:34]
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ebm_cfg_t   cfg_q, cfg_d;
  ebm_event_t front_evt, queue_evt;
  logic       front_valid, front_ready;
  logic       queue_valid, queue_ready;

  // Configuration register writes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ebm_cfg_idx_e'(cfg_index_i))
        CFG_PRESS_GAP:  cfg_d.press_gap_ms     = cfg_data_i[GapW-1:0];
        CFG_LONG_TICKS: cfg_d.long_press_ticks = cfg_data_i[TicksW-1:0];
        CFG_VALUE_MIN:  cfg_d.value_min        = cfg_data_i[ValueW-1:0];
        CFG_VALUE_MAX:  cfg_d.value_max        = cfg_data_i[ValueW-1:0];
        CFG_ANGLE_STEP: cfg_d.angle_step       = cfg_data_i[StepW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_gap_ms     <= PressGapReset;
      cfg_q.long_press_ticks <= LongTicksReset;
      cfg_q.value_min        <= ValueMinReset;
      cfg_q.value_max        <= ValueMaxReset;
      cfg_q.angle_step       <= AngleStepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front classifier.
  ebm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .now_ms_i       (s_axis_tdata[TimeW-1:0]),
    .enc_a_i        (s_axis_tdata[TimeW]),
    .enc_b_i        (s_axis_tdata[TimeW+1]),
    .button_level_i (s_axis_tdata[TimeW+2]),
    .evt_valid_o    (front_valid),
    .evt_ready_i    (front_ready),
    .evt_o          (front_evt)
  );

  // Event queue.
  ebm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_evt),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_evt)
  );

  // Back state machine and result register.
  ebm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (queue_valid),
    .evt_ready_o (queue_ready),
    .evt_i       (queue_evt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* dv/menu_state_checker.sv */
`timescale 1ns / 100ps
// Checker for the encoder button menu controller. It watches the tick, result and
// configuration channels, predicts every result and compares it. Depends on ebm_pkg.
module menu_state_checker
  import ebm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_valid_i,
  input  logic                tick_ready_i,
  // tick_data_i: now_ms[31:0], enc_a[32], enc_b[33], button_level[34], zeros[39:35]
  input  logic [InDataW-1:0]  tick_data_i,
  input  logic                view_valid_i,
  input  logic                view_ready_i,
  // view_data_i: cursor, editing, locked, three angles, all_matches, last_press_long,
  // rotated, zeros
  input  logic [OutDataW-1:0] view_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  // One result as the block packs it; the last member sits in the lowest bits.
  typedef struct packed {
    logic              rotated;
    logic              last_press_long;
    logic              all_matches;
    logic [AngleW-1:0] angle_right;
    logic [AngleW-1:0] angle_left;
    logic [AngleW-1:0] angle_all;
    logic              locked;
    logic              editing;
    logic [CursorW-1:0] cursor;
  } menu_view_t;

  localparam int unsigned ViewW = $bits(menu_view_t);

  // Copies of the configuration registers.
  logic [GapW-1:0]    gap_ms;
  logic [TicksW-1:0]  long_ticks;
  logic [ValueW-1:0]  val_min;
  logic [ValueW-1:0]  val_max;
  logic [StepW-1:0]   step_deg;

  // Copy of the menu and button state.
  logic               enc_level;
  logic [CursorW-1:0] cursor_pos;
  logic               edit_on;
  logic               lock_on;
  logic [ValueW-1:0]  setting [3];
  logic [TicksW-1:0]  hold_left;
  logic               long_seen;
  logic               armed;
  logic [TimeW-1:0]   last_low_ms;
  logic               kind_long;

  // Results predicted for accepted ticks, oldest first.
  menu_view_t expected_views [$];

  // Displayed angle of one setting; settings under the minimum show zero.
  function automatic logic [AngleW-1:0] angle_for(input logic [ValueW-1:0] v);
    int unsigned prod;
    if (v < val_min) return '0;
    prod = step_deg * (v - val_min);
    return AngleW'(prod);
  endfunction

  // Applies one tick to the state copy and returns the result it should produce.
  task automatic advance_menu(input logic [TimeW-1:0] now, input logic a, input logic b,
                              input logic btn, output menu_view_t view);
    logic              rise;
    logic              moved;
    int                slot;
    logic [ValueW-1:0] v;
    logic [TimeW-1:0]  since_low;
    rise = a && !enc_level;
    if (rise && !lock_on) begin
      if (!edit_on) begin
        if (b != a) cursor_pos = (cursor_pos == CursorRight) ? CursorAll : cursor_pos + 1'b1;
        else cursor_pos = (cursor_pos == CursorAll) ? CursorRight : cursor_pos - 1'b1;
      end else begin
        // Up and down limits are checked apart; min over max freezes values max to min.
        slot  = int'(cursor_pos) - 1;
        v     = setting[slot];
        moved = 1'b0;
        if (b != a && v < val_max) begin
          v     = v + 1'b1;
          moved = 1'b1;
        end else if (b == a && v > val_min) begin
          v     = v - 1'b1;
          moved = 1'b1;
        end
        if (moved) begin
          setting[slot] = v;
          // The "all" entry drags left and right along with it.
          if (slot == 0) begin
            setting[1] = v;
            setting[2] = v;
          end
        end
      end
    end
    if (rise && setting[1] == setting[2]) setting[0] = setting[1];
    enc_level = a;

    // Press detection by timestamp gap, then a held-tick countdown for long presses.
    if (!btn) begin
      since_low = now - last_low_ms;
      if (since_low > TimeW'(gap_ms)) begin
        hold_left = long_ticks;
        long_seen = 1'b0;
        armed     = 1'b1;
      end else if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else begin
        long_seen = 1'b1;
      end
      last_low_ms = now;
    end else if (armed) begin
      if (long_seen) begin
        armed     = 1'b0;
        kind_long = 1'b1;
        lock_on   = !lock_on;
      end else if (!lock_on) begin
        armed     = 1'b0;
        kind_long = 1'b0;
        edit_on   = !edit_on;
      end
    end

    view.cursor          = cursor_pos;
    view.editing         = edit_on;
    view.locked          = lock_on;
    view.angle_all       = angle_for(setting[0]);
    view.angle_left      = angle_for(setting[1]);
    view.angle_right     = angle_for(setting[2]);
    view.all_matches     = (setting[1] == setting[0]) && (setting[2] == setting[0]);
    view.last_press_long = kind_long;
    view.rotated         = rise;
  endtask

  // Counts one field mismatch; only the first few are reported in detail.
  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("Mismatch in result %0d, field %s: expected %0d, got %0d",
                 checked_o, name, want, got);
    end
  endtask

  task automatic compare_view(input menu_view_t want, input logic [OutDataW-1:0] raw);
    menu_view_t got;
    got = menu_view_t'(raw[ViewW-1:0]);
    note_field("cursor", want.cursor, got.cursor);
    note_field("editing", want.editing, got.editing);
    note_field("locked", want.locked, got.locked);
    note_field("angle_all", want.angle_all, got.angle_all);
    note_field("angle_left", want.angle_left, got.angle_left);
    note_field("angle_right", want.angle_right, got.angle_right);
    note_field("all_matches", want.all_matches, got.all_matches);
    note_field("last_press_long", want.last_press_long, got.last_press_long);
    note_field("rotated", want.rotated, got.rotated);
    note_field("padding", 0, raw[OutDataW-1:ViewW]);
  endtask

  // Configuration writes, result checks and tick predictions, in that order per edge.
  always @(posedge clk_i or negedge rst_ni) begin
    menu_view_t view;
    if (!rst_ni) begin
      gap_ms           = PressGapReset;
      long_ticks       = LongTicksReset;
      val_min          = ValueMinReset;
      val_max          = ValueMaxReset;
      step_deg         = AngleStepReset;
      enc_level        = 1'b0;
      cursor_pos       = CursorAll;
      edit_on          = 1'b0;
      lock_on          = 1'b0;
      setting[0]       = ValueMinReset;
      setting[1]       = ValueMinReset;
      setting[2]       = ValueMinReset;
      hold_left        = HoldCountReset;
      long_seen        = 1'b0;
      armed            = 1'b0;
      last_low_ms      = '0;
      kind_long        = 1'b0;
      expected_views.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (ebm_cfg_idx_e'(cfg_index_i))
          CFG_PRESS_GAP:  gap_ms     = cfg_data_i[GapW-1:0];
          CFG_LONG_TICKS: long_ticks = cfg_data_i[TicksW-1:0];
          CFG_VALUE_MIN:  val_min    = cfg_data_i[ValueW-1:0];
          CFG_VALUE_MAX:  val_max    = cfg_data_i[ValueW-1:0];
          CFG_ANGLE_STEP: step_deg   = cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end
      if (view_valid_i && view_ready_i) begin
        if (expected_views.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("Result transaction arrived with no tick waiting for it");
        end else begin
          compare_view(expected_views.pop_front(), view_data_i);
          checked_o++;
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        advance_menu(tick_data_i[TimeW-1:0], tick_data_i[TimeW], tick_data_i[TimeW+1],
                     tick_data_i[TimeW+2], view);
        expected_views.push_back(view);
      end
      pending_o = expected_views.size();
    end
  end

endmodule

/* dv/tb_encoder_button_menu_controller_top.sv */
`timescale 1ns / 100ps
// Testbench top for the encoder button menu controller: clock, reset, tick and
// register stimulus, and the verdict. Depends on ebm_pkg, the RTL and menu_state_checker.
module tb_encoder_button_menu_controller_top;
  import ebm_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int                  mismatch_count;
  int                  pending_count;
  int                  checked_count;

  // Stimulus knobs and bookkeeping.
  int                  sender_idle_pct;
  int                  receiver_idle_pct;
  logic [TimeW-1:0]    clock_ms;
  logic [GapW-1:0]     phase_gap;
  logic [TicksW-1:0]   phase_ticks;
  int                  detents_sent;
  int                  presses_sent;
  int                  settings_used;

  encoder_button_menu_controller_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  menu_state_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (s_axis_tvalid),
    .tick_ready_i     (s_axis_tready),
    .tick_data_i      (s_axis_tdata),
    .view_valid_i     (m_axis_tvalid),
    .view_ready_i     (m_axis_tready),
    .view_data_i      (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count),
    .checked_o        (checked_count)
  );

  // 12 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The receiver stalls at random with the current percentage.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Sends one tick transaction, with a random idle stretch in front. Called at a
  // falling edge; returns at the falling edge after the handshake with tvalid still high.
  task automatic send_tick(input logic [TimeW-1:0] now, input logic a, input logic b,
                           input logic btn);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, btn, b, a, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all five registers back to back, one transaction each.
  task automatic load_settings(input logic [GapW-1:0] gap, input logic [TicksW-1:0] ticks,
                               input logic [ValueW-1:0] vmin, input logic [ValueW-1:0] vmax,
                               input logic [StepW-1:0] step);
    logic [CfgDataW-1:0] reg_vals [5];
    ebm_cfg_idx_e        idx;
    reg_vals[CFG_PRESS_GAP]  = gap;
    reg_vals[CFG_LONG_TICKS] = ticks;
    reg_vals[CFG_VALUE_MIN]  = CfgDataW'(vmin);
    reg_vals[CFG_VALUE_MAX]  = CfgDataW'(vmax);
    reg_vals[CFG_ANGLE_STEP] = CfgDataW'(step);
    idx = CFG_PRESS_GAP;
    repeat (5) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= reg_vals[idx];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    phase_gap   = gap;
    phase_ticks = ticks;
    settings_used++;
  endtask

  // Random traffic: mostly encoder detents and well-formed presses, some raw noise.
  task automatic play_phase(input int n_ticks);
    int               sent;
    int               pick;
    int               held;
    int               releases;
    logic             b;
    logic [TimeW-1:0] noise_ms;
    sent = 0;
    while (sent < n_ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // One detent: clock line low, then high with a random direction.
        b = 1'($urandom_range(0, 1));
        clock_ms += $urandom_range(0, 3);
        send_tick(clock_ms, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        clock_ms += $urandom_range(0, 3);
        send_tick(clock_ms, 1'b1, b, 1'b1);
        sent += 2;
        detents_sent++;
      end else if (pick < 80) begin
        // A press that opens after a long enough gap, is held, then released.
        held = (phase_ticks < 10) ? $urandom_range(1, phase_ticks + 3) : $urandom_range(1, 8);
        releases = $urandom_range(1, 2);
        clock_ms += phase_gap + 1 + $urandom_range(0, 40);
        repeat (held) begin
          send_tick(clock_ms, 1'b0, 1'($urandom_range(0, 1)), 1'b0);
          clock_ms += $urandom_range(0, (phase_gap < 2) ? phase_gap : 2);
        end
        repeat (releases) send_tick(clock_ms, 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        sent += held + releases;
        presses_sent++;
      end else begin
        noise_ms = $urandom;
        send_tick(noise_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        clock_ms = noise_ms;
        sent++;
      end
    end
  endtask

  initial begin
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    m_axis_tready     = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_PRESS_GAP;
    cfg_data_i        = '0;
    rst_ni            = 1'b0;
    sender_idle_pct   = 29;
    receiver_idle_pct = 57;
    clock_ms          = '0;
    phase_gap         = PressGapReset;
    phase_ticks       = LongTicksReset;
    detents_sent      = 0;
    presses_sent      = 0;
    settings_used     = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed ticks at the reset settings: a release with no press pending,
    // reverse and forward cursor moves, a short press into edit mode, and stepping
    // the ganged value up and back down against the minimum.
    send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b1);
    send_tick(32'd1, 1'b1, 1'b1, 1'b1);
    send_tick(32'd2, 1'b0, 1'b0, 1'b1);
    send_tick(32'd3, 1'b1, 1'b0, 1'b1);
    send_tick(32'd100, 1'b0, 1'b0, 1'b0);
    send_tick(32'd101, 1'b0, 1'b0, 1'b1);
    send_tick(32'd102, 1'b1, 1'b0, 1'b1);
    send_tick(32'd103, 1'b0, 1'b1, 1'b1);
    send_tick(32'd104, 1'b1, 1'b1, 1'b1);
    send_tick(32'd105, 1'b0, 1'b0, 1'b1);
    send_tick(32'd106, 1'b1, 1'b1, 1'b1);

    // With a one-tick long press: a long press across the timestamp wrap that
    // locks, rotation while locked in both directions, a short press ignored while
    // locked, then the countdown running out again to unlock.
    wait_drained();
    load_settings(16'd50, 16'd1, 5'd8, 5'd18, 4'd9);
    send_tick(32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_tick(32'h0000_0002, 1'b0, 1'b0, 1'b0);
    send_tick(32'd3, 1'b0, 1'b0, 1'b1);
    send_tick(32'd4, 1'b1, 1'b1, 1'b1);
    send_tick(32'd5, 1'b0, 1'b0, 1'b1);
    send_tick(32'd6, 1'b1, 1'b0, 1'b1);
    send_tick(32'd7, 1'b0, 1'b0, 1'b1);
    send_tick(32'd100, 1'b0, 1'b0, 1'b0);
    send_tick(32'd101, 1'b0, 1'b0, 1'b1);
    send_tick(32'd102, 1'b0, 1'b0, 1'b0);
    send_tick(32'd103, 1'b0, 1'b0, 1'b0);
    send_tick(32'd104, 1'b0, 1'b0, 1'b1);
    clock_ms = 32'd200;

    // Random phases over several register settings, extremes included.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      sender_idle_pct   = (p < 2) ? 29 : (p < 4) ? 57 : 0;
      receiver_idle_pct = (p < 2) ? 57 : (p < 4) ? 29 : 0;
      case (p)
        0: load_settings(16'd0, 16'd0, 5'd0, 5'd31, 4'd15);
        1: load_settings(16'd65535, 16'd3, 5'd4, 5'd31, 4'd15);
        // Minimum above maximum; values left under the new minimum show angle zero.
        2: load_settings(16'd20, 16'd5, 5'd20, 5'd5, 4'd7);
        3: load_settings(16'd7, 16'd1, 5'd0, 5'd0, 4'd1);
        4: load_settings(16'd65535, 16'd65535, 5'd31, 5'd31, 4'd0);
        default: load_settings(16'd30, 16'd4, 5'd2, 5'd29, 4'd11);
      endcase
      play_phase(108);
    end
    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d results under %0d register settings: %0d random detents,",
             checked_count, settings_used, detents_sent);
    $display("%0d random presses, plus directed lock, wrap and limit ticks.", presses_sent);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
